FILE: design/aid_pkg.sv
// Shared types and constants for the authorised identifier table.
// Used by aid_table and authorized_id_table_top; depends on nothing else.
`default_nettype none

package aid_pkg;

  localparam int ID_W     = 32;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_SPECIAL = 1'b1;

  // Request kinds.
  localparam logic REQ_LOOKUP   = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Commands from the sequencer to the table store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } tbl_cmd_t;

endpackage

`default_nettype wire

FILE: design/aid_table.sv
// Identifier store with a registered read port and the shared comparator.
// Depends on aid_pkg for the command struct and the identifier width.
`default_nettype none

module aid_table #(
  parameter int ENTRIES = 128
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire aid_pkg::tbl_cmd_t     cmd,
  input  wire [$clog2(ENTRIES)-1:0]  addr,
  input  wire [aid_pkg::ID_W-1:0]    key,
  output logic                       match
);
  import aid_pkg::*;

  logic [ID_W-1:0] mem [ENTRIES];
  logic [ID_W-1:0] rd_q;
  logic            rd_vld;

  // The key doubles as the write data: a registration stores the identifier
  // that has just been searched for.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= key;
    end
    if (cmd.rd) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      match  <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (cmd.clr) begin
        match <= 1'b0;
      end else if (rd_vld && (rd_q == key)) begin
        match <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/authorized_id_table_top.sv
// Top level of the authorised identifier table: sequencer, configuration,
// result register. Depends on aid_pkg and instantiates aid_table.
`default_nettype none

//  channel   handshake                 payload
//  --------  ------------------------  --------------------------------------
//  request   in_valid / in_stall       req_type, process_id, process_valid
//  result    out_valid / out_stall     authorized, status, slot, stored
//  config    cfg_we                    cfg_index, cfg_data
//
// An enabled item walks the single read port of the table store one slot a
// cycle past one shared comparator, over the fill occupied slots (fill being
// the number of occupied slots); the match flag then settles in the wait
// state and the decision is made in the done state. A disabled block goes
// straight to the done state. The sequencer then returns to idle before it
// takes the next item, so a new item is not accepted until the last one has
// left the sequencer.
// Occupied slots always form a prefix of the table, so a fill count replaces
// any clearing pass: the block is ready straight after reset.
// A new request is taken while the previous result is still stalled; the
// sequencer then holds its finished result until the output register frees.

module authorized_id_table_top #(
  parameter int ENTRIES = 128
) (
  input  wire                            clk,
  input  wire                            rst,
  // request channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            req_type,
  input  wire [aid_pkg::ID_W-1:0]        process_id,
  input  wire                            process_valid,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           authorized,
  output logic [aid_pkg::STATUS_W-1:0]   status,
  output logic [aid_pkg::SLOT_W-1:0]     slot,
  output logic                           stored,
  // configuration
  input  wire                            cfg_we,
  input  wire                            cfg_index,
  input  wire [aid_pkg::ID_W-1:0]        cfg_data
);
  import aid_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t state, state_next;

  // Configuration registers.
  logic            enabled;
  logic [ID_W-1:0] special_id;

  // Request held for the duration of the search.
  logic            req_q;
  logic [ID_W-1:0] id_q;
  logic            pv_q;

  // Scan index, fill count and replacement pointer.
  logic [CW-1:0] idx;
  logic [CW-1:0] fill;
  logic [AW-1:0] victim;

  tbl_cmd_t      cmd;
  logic [AW-1:0] tbl_addr;
  logic          match;

  // Decision made in the final state.
  logic                auth;
  logic                do_store;
  logic [STATUS_W-1:0] res_status;
  logic                full;
  logic [AW-1:0]       slot_idx;
  logic [AW+SLOT_W-1:0] slot_wide;
  logic                fire;
  logic                accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      special_id <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED: enabled    <= cfg_data[0];
        REG_SPECIAL: special_id <= cfg_data;
        default:     enabled    <= enabled;
      endcase
    end
  end

  // An identifier of zero is never authorised; the special identifier only
  // counts when it is itself nonzero.
  assign full     = (fill == CW'(ENTRIES));
  assign auth     = enabled && (id_q != '0) &&
                    (match || ((special_id != '0) && (special_id == id_q)));
  assign do_store = enabled && (req_q == REQ_REGISTER) && !auth &&
                    (id_q != '0) && pv_q;
  assign slot_idx = full ? victim : fill[AW-1:0];
  assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};

  always_comb begin
    if (!enabled) begin
      res_status = ST_DISABLED;
    end else if ((req_q == REQ_REGISTER) && !auth && ((id_q == '0) || !pv_q)) begin
      res_status = ST_INVALID;
    end else begin
      res_status = ST_OK;
    end
  end

  // The result leaves the sequencer once the output register is free.
  assign fire = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cmd        = '0;
    tbl_addr   = slot_idx;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.clr = accept;
        if (accept) begin
          state_next = enabled ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        tbl_addr = idx[AW-1:0];
        if (idx < fill) begin
          cmd.rd = 1'b1;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        // The last read was compared in the final scan cycle; the match flag
        // settles here.
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.wr = fire && do_store;
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      fill   <= '0;
      victim <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx <= '0;
      end else if (cmd.rd) begin
        idx <= idx + 1'b1;
      end
      if (cmd.wr) begin
        if (full) begin
          victim <= (victim == AW'(ENTRIES - 1)) ? '0 : victim + 1'b1;
        end else begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_type;
      id_q  <= process_id;
      pv_q  <= process_valid;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      authorized <= auth;
      status     <= res_status;
      slot       <= do_store ? slot_wide[SLOT_W-1:0] : '0;
      stored     <= do_store;
    end
  end

  aid_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .addr  (tbl_addr),
    .key   (id_q),
    .match (match)
  );

endmodule

`default_nettype wire

FILE: dv/authorized_id_table_top_tb.sv
// Self-checking testbench for authorized_id_table_top: directed and random
// lookup and register requests against a table model kept in a scoreboard class.
// Depends on aid_pkg and the design top level only.

module authorized_id_table_top_tb;

  import aid_pkg::*;

  localparam int TABLE_DEPTH  = 128;
  localparam int ITEM_TARGET  = 1050;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 1000000;

  // One result item as the block presents it.
  typedef struct packed {
    logic                authorized;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                stored;
  } id_result_t;

  // The scoreboard mirrors the identifier table, the victim pointer and both
  // registers, and queues the result that each accepted request must produce.
  class aid_scoreboard;
    logic [ID_W-1:0] id_slots [TABLE_DEPTH];
    int              victim;
    logic            enabled_q;
    logic [ID_W-1:0] special_q;
    id_result_t      expected_q [$];
    int unsigned     errors;

    function new();
      foreach (id_slots[i]) id_slots[i] = '0;
      victim    = 0;
      enabled_q = 1'b0;
      special_q = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [ID_W-1:0] data);
      if (idx == REG_ENABLED) enabled_q = data[0];
      else special_q = data;
    endfunction

    function logic holds_id(logic [ID_W-1:0] id);
      if (id == '0) return 1'b0;
      if (special_q != '0 && special_q == id) return 1'b1;
      foreach (id_slots[i]) if (id_slots[i] == id) return 1'b1;
      return 1'b0;
    endfunction

    function void note_request(logic req, logic [ID_W-1:0] id, logic pv);
      id_result_t res;
      int         free_at;
      res = '0;
      res.status = ST_OK;
      if (!enabled_q) begin
        res.status = ST_DISABLED;
      end else begin
        res.authorized = holds_id(id);
        if (req == REQ_REGISTER && !res.authorized) begin
          if (id == '0 || !pv) begin
            res.status = ST_INVALID;
          end else begin
            free_at = -1;
            foreach (id_slots[i]) if (free_at < 0 && id_slots[i] == '0) free_at = i;
            if (free_at < 0) begin
              free_at = victim;
              victim = (victim + 1) % TABLE_DEPTH;
            end
            id_slots[free_at] = id;
            res.slot   = SLOT_W'(free_at);
            res.stored = 1'b1;
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void compare_field(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(id_result_t got);
      id_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("authorized", ID_W'(want.authorized), ID_W'(got.authorized));
      compare_field("status", ID_W'(want.status), ID_W'(got.status));
      compare_field("slot", ID_W'(want.slot), ID_W'(got.slot));
      compare_field("stored", ID_W'(want.stored), ID_W'(got.stored));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // An identifier that is probably in the table, so that hits are common.
    function logic [ID_W-1:0] pick_known();
      int idx;
      repeat (8) begin
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        if (id_slots[idx] != '0) return id_slots[idx];
      end
      return $urandom;
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            req_type = 1'b0;
  logic [ID_W-1:0] process_id = '0;
  logic            process_valid = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            authorized;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic            stored;
  logic            cfg_we = 1'b0;
  logic            cfg_index = 1'b0;
  logic [ID_W-1:0] cfg_data = '0;

  aid_scoreboard sb;
  int unsigned   sent_items = 0;
  int unsigned   cycles = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  bit            rx_hold_req = 1'b0;

  authorized_id_table_top #(.ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .process_id(process_id), .process_valid(process_valid),
    .out_valid(out_valid), .out_stall(out_stall),
    .authorized(authorized), .status(status), .slot(slot), .stored(stored),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A random single bit.
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 50);
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Both handshakes are sampled just after the rising edge. Every input is
  // driven by nonblocking assignment, so the values read here are those that
  // the block saw at that same edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_request(req_type, process_id, process_valid);
    if (!rst && out_valid && !out_stall) sb.check_result({authorized, status, slot, stored});
  end

  // Receiver. Normally it stalls in random bursts, or not at all during a
  // quiet phase. On request it holds off for a long stretch, so that the block
  // fills its result register and its sequencer and then stalls the sender.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0 && !rx_quiet) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = stall_length();
      end
    end
  end

  // A run that never drains ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one item and returns at the edge at which it is taken. The valid is
  // left high, so that a following item is offered straight away.
  task automatic send_item(input logic req, input logic [ID_W-1:0] id, input logic pv);
    in_valid      <= 1'b1;
    req_type      <= req;
    process_id    <= id;
    process_valid <= pv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic do_item(input logic req, input logic [ID_W-1:0] id, input logic pv);
    int gap;
    send_item(req, id, pv);
    gap = tx_quiet ? 0 : sender_gap();
    if (gap > 0) pause(gap);
  endtask

  // Stops sending and waits for every outstanding result. Each request gives
  // exactly one result, so the block is idle once nothing is expected.
  task automatic drain();
    pause(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the enable stays high between.
  task automatic set_config(input logic en, input logic [ID_W-1:0] sid);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENABLED;
    cfg_data  <= {{(ID_W-1){1'b0}}, en};
    @(posedge clk);
    sb.set_reg(REG_ENABLED, {{(ID_W-1){1'b0}}, en});
    cfg_index <= REG_SPECIAL;
    cfg_data  <= sid;
    @(posedge clk);
    sb.set_reg(REG_SPECIAL, sid);
    cfg_we <= 1'b0;
  endtask

  // One random request. Most are fresh registrations, which fill the table and
  // then drive round-robin replacement, and lookups or re-registrations of
  // identifiers already held; the rest cover random lookups, zero, the special
  // identifier, small colliding values, refused registrations and the all-ones and top-bit-only values.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) do_item(REQ_REGISTER, $urandom, 1'b1);
    else if (r < 50) do_item(REQ_LOOKUP, sb.pick_known(), coin());
    else if (r < 58) do_item(REQ_REGISTER, sb.pick_known(), coin());
    else if (r < 70) do_item(REQ_LOOKUP, $urandom, coin());
    else if (r < 76) do_item(REQ_REGISTER, $urandom, 1'b0);
    else if (r < 81) do_item(coin(), '0, coin());
    else if (r < 86) do_item(coin(), sb.special_q, coin());
    else if (r < 92) do_item(coin(), $urandom_range(1, 15), coin());
    else if (r < 96) begin
      do_item(coin(), $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000, coin());
    end else begin
      // The sender waits here until every result has come back.
      do_item(REQ_LOOKUP, $urandom, 1'b0);
      drain();
    end
  endtask

  initial begin
    int               phase;
    int               len;
    int               pick;
    logic             en;
    logic [ID_W-1:0]  sid;

    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight after reset the block is disabled and must refuse everything.
    do_item(REQ_LOOKUP, 32'h0000_0001, 1'b0);
    do_item(REQ_REGISTER, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Enabled, with the all-ones special identifier.
    set_config(1'b1, 32'hFFFF_FFFF);
    do_item(REQ_LOOKUP, '0, 1'b0);
    do_item(REQ_REGISTER, '0, 1'b1);
    do_item(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1);
    do_item(REQ_REGISTER, 32'hFFFF_FFFF, 1'b1);
    do_item(REQ_REGISTER, 32'h0000_0001, 1'b0);
    do_item(REQ_REGISTER, 32'h0000_0001, 1'b1);
    do_item(REQ_LOOKUP, 32'h0000_0001, 1'b0);
    do_item(REQ_REGISTER, 32'h0000_0001, 1'b1);
    do_item(REQ_LOOKUP, 32'h0000_0002, 1'b1);
    do_item(REQ_REGISTER, 32'hFFFF_FFFE, 1'b1);
    do_item(REQ_REGISTER, 32'h8000_0000, 1'b1);
    do_item(REQ_REGISTER, 32'h7FFF_FFFF, 1'b1);
    drain();

    // A zero special identifier authorises nothing by itself.
    set_config(1'b1, '0);
    do_item(REQ_LOOKUP, '0, 1'b1);
    do_item(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    do_item(REQ_REGISTER, 32'hFFFF_FFFF, 1'b1);
    do_item(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Disabled again with entries present: the table must be left alone.
    set_config(1'b0, 32'h0000_0001);
    do_item(REQ_LOOKUP, 32'h0000_0001, 1'b0);
    do_item(REQ_REGISTER, 32'h1234_5678, 1'b1);
    drain();

    // Random phases, each with its own register settings and idling style.
    // Phases two and seven carry a long receiver hold-off with a busy sender.
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      en = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 4);
      if (pick == 0) sid = '0;
      else if (pick == 1) sid = 32'hFFFF_FFFF;
      else if (pick == 2) sid = sb.pick_known();
      else sid = $urandom;
      set_config(en, sid);
      len = en ? $urandom_range(30, 90) : $urandom_range(5, 15);
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      if (phase == 2 || phase == 7) begin
        tx_quiet = 1'b1;
        rx_hold_req = 1'b1;
      end
      repeat (len) random_item();
      drain();
      phase++;
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
